// ===== rtl/core/spu_pkg.sv =====
`default_nettype none

package spu_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int FRAC_W   = 16;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic shift;
        logic shift_zero;
        logic clear;
        logic issue;
        logic last;
        logic done;
    } spu_cmd_t;

    // shift-subtract division, elaboration only
    function automatic longint unsigned spu_udiv(longint unsigned n, longint unsigned dv);
        longint unsigned q;
        longint unsigned rem;
        int i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], n[i]};
            if (rem >= dv)
            begin
                rem  = rem - dv;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(pi*a/r) in q30, taylor series
    function automatic longint spu_sin_q30(int r, int a);
        longint unsigned x;
        longint unsigned mag;
        longint sum;
        int n;
        x   = spu_udiv(PI_Q30 * longint'(a), longint'(r));
        mag = x;
        sum = longint'(x);
        for (n = 1; n <= 12; n++)
        begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            mag = spu_udiv(mag, longint'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1)
                sum = sum - longint'(mag);
            else
                sum = sum + longint'(mag);
        end
        return sum;
    endfunction

    // sinc tap at distance d for factor r, q2.16 rounded
    function automatic logic signed [COEF_W-1:0] spu_coef(int r, int d);
        longint unsigned q;
        int a;
        longint s;
        longint unsigned num;
        longint unsigned den;
        longint unsigned c;
        longint sc;
        if (d == 0)
            return COEF_W'(65536);
        q = spu_udiv(longint'(d), longint'(r));
        a = d - int'(q) * r;
        if (2 * a > r)
            a = r - a;
        s = spu_sin_q30(r, a);
        if (s < 0)
            s = 0;
        num = longint'(s) * longint'(r) * 64'd65536;
        den = PI_Q30 * longint'(d);
        c   = spu_udiv(2 * num + den, 2 * den);
        sc  = q[0] ? -longint'(c) : longint'(c);
        return sc[COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spu_ctrl.sv =====
`default_nettype none

module spu_ctrl #(
    parameter int UPSAMPLE_FACTOR = 4,
    parameter int LOBE_RADIUS     = 4,
    parameter int PH_W            = 2
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    end_of_record,
    input  wire                    pipe_en,
    output spu_pkg::spu_cmd_t      cmd,
    output logic [PH_W-1:0]        phase
);
    import spu_pkg::*;

    localparam int CNT_W = $clog2(LOBE_RADIUS + 1);
    localparam logic [CNT_W-1:0] L_CNT     = CNT_W'(LOBE_RADIUS);
    localparam logic [CNT_W:0]   L_CNT_EXT = (CNT_W + 1)'(LOBE_RADIUS);
    localparam logic [PH_W-1:0]  PH_LAST   = PH_W'(UPSAMPLE_FACTOR - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [CNT_W-1:0] warm_reg, warm_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             eor_reg, eor_next;
    logic             flush_reg, flush_next;
    logic             ph_last;
    logic             final_group;
    logic             flush_hit;

    assign phase       = phase_reg;
    assign ph_last     = (phase_reg == PH_LAST);
    assign final_group = flush_reg && (step_reg == L_CNT);
    // group due once the flush step reaches a pending input
    assign flush_hit   = ({1'b0, step_reg} + {1'b0, warm_reg}) > L_CNT_EXT;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        warm_next  = warm_reg;
        step_next  = step_reg;
        eor_next   = eor_reg;
        flush_next = flush_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EMIT:
            begin
                if (pipe_en)
                begin
                    cmd.issue = 1'b1;
                    cmd.last  = ph_last && (!eor_reg || final_group);
                    cmd.done  = ph_last && final_group;
                    if (!ph_last)
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = '0;
                        if (flush_reg)
                        begin
                            if (step_reg == L_CNT)
                            begin
                                cmd.clear  = 1'b1;
                                warm_next  = '0;
                                flush_next = 1'b0;
                                eor_next   = 1'b0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                step_next  = step_reg + 1'b1;
                                state_next = ST_FLUSH;
                            end
                        end
                        else if (eor_reg)
                        begin
                            step_next  = CNT_W'(1);
                            flush_next = 1'b1;
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            in_ready   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.shift      = 1'b1;
                cmd.shift_zero = 1'b1;
                if (flush_hit)
                    state_next = ST_EMIT;
                else
                    step_next = step_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // request taken: shift in the sample and decide what follows
        if (in_ready && in_valid)
        begin
            cmd.shift  = 1'b1;
            eor_next   = end_of_record;
            flush_next = 1'b0;
            phase_next = '0;
            if (warm_reg >= L_CNT)
            begin
                state_next = ST_EMIT;
            end
            else
            begin
                warm_next = warm_reg + 1'b1;
                if (end_of_record)
                begin
                    step_next  = CNT_W'(1);
                    flush_next = 1'b1;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            warm_reg  <= '0;
            step_reg  <= '0;
            eor_reg   <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            warm_reg  <= warm_next;
            step_reg  <= step_next;
            eor_reg   <= eor_next;
            flush_reg <= flush_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/spu_datapath.sv =====
`default_nettype none

module spu_datapath #(
    parameter int UPSAMPLE_FACTOR = 4,
    parameter int LOBE_RADIUS     = 4,
    parameter int PH_W            = 2
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire signed [spu_pkg::SAMPLE_W-1:0]   sample,
    input  spu_pkg::spu_cmd_t                    cmd,
    input  wire [PH_W-1:0]                       phase,
    output logic                                 pipe_en,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [spu_pkg::SAMPLE_W-1:0]  value,
    output logic                                 last_of_run,
    output logic                                 record_done
);
    import spu_pkg::*;

    localparam int NT  = 2 * LOBE_RADIUS + 1;
    localparam int HT  = LOBE_RADIUS * UPSAMPLE_FACTOR;
    localparam int GS  = 4;
    localparam int NG  = (NT + GS - 1) / GS;
    localparam int PW  = SAMPLE_W + COEF_W;
    localparam int GW  = PW + $clog2(GS);
    localparam int AW  = GW + $clog2(NG + 1);
    localparam int RW  = AW - FRAC_W;
    localparam logic signed [AW-1:0] HALF_LSB = AW'(1) <<< (FRAC_W - 1);
    localparam logic signed [RW-1:0] SAT_MAX  = RW'(32767);
    localparam logic signed [RW-1:0] SAT_MIN  = -RW'(32768);

    logic signed [SAMPLE_W-1:0] hist_reg [NT];
    logic signed [COEF_W-1:0]   tab      [NT][UPSAMPLE_FACTOR];

    logic signed [PW-1:0]       prod_reg [NT];
    logic                       v1_reg, last1_reg, done1_reg;
    logic signed [GW-1:0]       grp_term [NG][GS];
    logic signed [GW-1:0]       grp_next [NG];
    logic signed [GW-1:0]       grp_reg  [NG];
    logic                       v2_reg, last2_reg, done2_reg;
    logic signed [AW-1:0]       acc;
    logic signed [RW-1:0]       rnd;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic                       last_reg, done_reg;

    // whole pipeline holds while the output waits
    assign pipe_en     = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign last_of_run = last_reg;
    assign record_done = done_reg;

    // per tap, per phase coefficient rom
    for (genvar k = 0; k < NT; k++)
    begin : g_tap
        for (genvar p = 0; p < UPSAMPLE_FACTOR; p++)
        begin : g_ph
            localparam int OFS  = p - (k - LOBE_RADIUS) * UPSAMPLE_FACTOR;
            localparam int DIST = (OFS < 0) ? -OFS : OFS;
            localparam logic signed [COEF_W-1:0] C =
                (DIST <= HT) ? spu_coef(UPSAMPLE_FACTOR, DIST) : '0;
            assign tab[k][p] = C;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
                hist_reg[i] <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < NT; i++)
                hist_reg[i] <= '0;
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < NT - 1; i++)
                hist_reg[i] <= hist_reg[i + 1];
            hist_reg[NT-1] <= cmd.shift_zero ? '0 : sample;
        end
    end

    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        for (genvar j = 0; j < GS; j++)
        begin : g_term
            if (g * GS + j < NT)
            begin : g_on
                assign grp_term[g][j] = GW'(prod_reg[g * GS + j]);
            end
            else
            begin : g_off
                assign grp_term[g][j] = '0;
            end
        end

        always_comb
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GS; j++)
                grp_next[g] = grp_next[g] + grp_term[g][j];
        end
    end

    always_comb
    begin
        acc = HALF_LSB;
        for (int g = 0; g < NG; g++)
            acc = acc + AW'(grp_reg[g]);
        rnd = RW'(acc >>> FRAC_W);
        if (rnd > SAT_MAX)
            value_next = SAMPLE_W'(SAT_MAX);
        else if (rnd < SAT_MIN)
            value_next = SAMPLE_W'(SAT_MIN);
        else
            value_next = rnd[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int k = 0; k < NT; k++)
                prod_reg[k] <= hist_reg[k] * tab[k][phase];
            last1_reg <= cmd.last;
            done1_reg <= cmd.done;
            for (int g = 0; g < NG; g++)
                grp_reg[g] <= grp_next[g];
            last2_reg <= last1_reg;
            done2_reg <= done1_reg;
            value_reg <= value_next;
            last_reg  <= last2_reg;
            done_reg  <= done2_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sinc_polyphase_upsampler_top.sv =====
`default_nettype none

// each sample emits a group of UPSAMPLE_FACTOR outputs once LOBE_RADIUS later samples are in
// steady state: one output issued per cycle, held while the output waits
// a warmup sample is only shifted in; end_of_record adds LOBE_RADIUS zero shifts,
// each followed by its group once it centers a pending sample; back to idle after the flush
// after issue an output passes the multiply, group add, and round and saturate stages
// reset: sample history and warmup count clear to zero, no output pending

module sinc_polyphase_upsampler_top #(
    parameter int UPSAMPLE_FACTOR = 4,
    parameter int LOBE_RADIUS     = 4
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire signed [spu_pkg::SAMPLE_W-1:0]   sample,
    input  wire                                  end_of_record,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [spu_pkg::SAMPLE_W-1:0]  value,
    output logic                                 last_of_run,
    output logic                                 record_done
);
    import spu_pkg::*;

    localparam int PH_W = $clog2(UPSAMPLE_FACTOR);

    spu_cmd_t        cmd;
    logic [PH_W-1:0] phase;
    logic            pipe_en;

    spu_ctrl #(
        .UPSAMPLE_FACTOR (UPSAMPLE_FACTOR),
        .LOBE_RADIUS     (LOBE_RADIUS),
        .PH_W            (PH_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .end_of_record (end_of_record),
        .pipe_en       (pipe_en),
        .cmd           (cmd),
        .phase         (phase)
    );

    spu_datapath #(
        .UPSAMPLE_FACTOR (UPSAMPLE_FACTOR),
        .LOBE_RADIUS     (LOBE_RADIUS),
        .PH_W            (PH_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .cmd         (cmd),
        .phase       (phase),
        .pipe_en     (pipe_en),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .last_of_run (last_of_run),
        .record_done (record_done)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int SW        = spu_pkg::SAMPLE_W;
    localparam int UPS       = 4;
    localparam int LOBE      = 4;
    localparam int HIST      = 2 * LOBE + 1;
    localparam int HALF      = LOBE * UPS;
    localparam int HOLD_AT   = 30;
    localparam int HOLD_LEN  = 300;
    localparam int TAIL_WAIT = 32;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic                 eor;
        int                   idle_pct;
        int                   stall_pct;
        bit                   drain;
    } sample_req_t;

    typedef struct {
        logic signed [SW-1:0] val;
        logic                 last;
        logic                 done;
    } interp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [SW-1:0] sample = '0;
    logic                 end_of_record = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [SW-1:0] value;
    logic                 last_of_run;
    logic                 record_done;

    sample_req_t          sample_reqs[$];
    interp_t              interp_q[$];
    longint               sinc_tap [0:HALF];
    logic signed [SW-1:0] hist [0:HIST-1];
    int                   warm = 0;
    int                   n_accepted = 0;
    int                   n_total = 0;
    int                   recv_stall = 0;
    logic                 hold_on = 1'b0;
    int                   errors = 0;

    sinc_polyphase_upsampler_top #(
        .UPSAMPLE_FACTOR(UPS),
        .LOBE_RADIUS(LOBE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample(sample),
        .end_of_record(end_of_record),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value(value),
        .last_of_run(last_of_run),
        .record_done(record_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #400000;
        $display("sinc_polyphase_upsampler_top test failed");
        $finish;
    end

    // truncated sinc taps in q2.16, sine by taylor series in q30
    initial
    begin : build_taps
        longint unsigned x;
        longint unsigned mag;
        longint          s;
        longint          num;
        longint          den;
        longint          c;
        int              d;
        int              a;
        int              n;
        sinc_tap[0] = 65536;
        for (d = 1; d <= HALF; d++)
        begin
            a = d % UPS;
            if (2 * a > UPS)
                a = UPS - a;
            x   = (PI_Q30 * longint'(a)) / longint'(UPS);
            mag = x;
            s   = longint'(x);
            for (n = 1; n <= 12; n++)
            begin
                mag = (mag * x) >> 30;
                mag = (mag * x) >> 30;
                mag = mag / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - longint'(mag);
                else
                    s = s + longint'(mag);
            end
            if (s < 0)
                s = 0;
            num = s * UPS * 65536;
            den = longint'(PI_Q30) * d;
            c   = (2 * num + den) / (2 * den);
            sinc_tap[d] = ((d / UPS) % 2 == 1) ? -c : c;
        end
        for (d = 0; d < HIST; d++)
            hist[d] = '0;
    end

    task automatic flag_error(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void shift_hist(logic signed [SW-1:0] v);
        int i;
        for (i = 0; i < HIST - 1; i++)
            hist[i] = hist[i+1];
        hist[HIST-1] = v;
    endfunction

    // one group of UPS outputs centred on the middle of the history
    function automatic void emit_group();
        interp_t r;
        longint  acc;
        longint  q;
        int      p;
        int      m;
        int      d;
        for (p = 0; p < UPS; p++)
        begin
            acc = 0;
            for (m = -LOBE; m <= LOBE; m++)
            begin
                d = p - m * UPS;
                if (d < 0)
                    d = -d;
                if (d <= HALF)
                    acc += longint'(hist[LOBE+m]) * sinc_tap[d];
            end
            q = (acc + 32768) >>> 16;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            r.val  = q[SW-1:0];
            r.last = 1'b0;
            r.done = 1'b0;
            interp_q.insert(interp_q.size(), r);
        end
    endfunction

    function automatic void interpolate_sample(logic signed [SW-1:0] s, logic eor);
        int      n0;
        int      k;
        n0 = interp_q.size();
        shift_hist(s);
        if (warm >= LOBE)
        begin
            warm = LOBE;
            emit_group();
        end
        else
            warm++;
        if (eor)
        begin
            // flush: zeros past the end bring pending samples to the centre
            for (k = 1; k <= LOBE; k++)
            begin
                shift_hist('0);
                if (k >= LOBE - warm + 1)
                    emit_group();
            end
            for (k = 0; k < HIST; k++)
                hist[k] = '0;
            warm = 0;
        end
        if (interp_q.size() > n0)
        begin
            interp_q[interp_q.size() - 1].last = 1'b1;
            interp_q[interp_q.size() - 1].done = eor;
        end
    endfunction

    task automatic queue_sample(logic signed [SW-1:0] s, logic eor, int idle, int stall,
                                bit drain);
        sample_req_t req;
        req.smp       = s;
        req.eor       = eor;
        req.idle_pct  = idle;
        req.stall_pct = stall;
        req.drain     = drain;
        sample_reqs.insert(sample_reqs.size(), req);
        n_total++;
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SW'($urandom_range(16)) - 16'sd8;
            default: return SW'($urandom());
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive
        sample_req_t req;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            sample        <= '0;
            end_of_record <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                interpolate_sample(sample, end_of_record);
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_reqs.size() > 0
                    && !(sample_reqs[0].drain && interp_q.size() > 0)
                    && $urandom_range(99) >= sample_reqs[0].idle_pct)
                begin
                    req = sample_reqs.pop_front();
                    in_valid      <= 1'b1;
                    sample        <= req.smp;
                    end_of_record <= req.eor;
                    recv_stall    <= req.stall_pct;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : observe
        interp_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (interp_q.size() == 0)
                    flag_error($sformatf("unexpected output value %0d", value));
                else
                begin
                    want = interp_q.pop_front();
                    if (value !== want.val)
                        flag_error($sformatf("value %0d, expected %0d", value, want.val));
                    if (last_of_run !== want.last)
                        flag_error($sformatf("last_of_run %b, expected %b",
                                             last_of_run, want.last));
                    if (record_done !== want.done)
                        flag_error($sformatf("record_done %b, expected %b",
                                             record_done, want.done));
                end
            end
            out_ready <= !hold_on && ($urandom_range(99) >= recv_stall);
        end
    end

    // long output hold-off so the block backs up and stalls its input
    initial
    begin
        @(posedge rst_n);
        while (n_accepted < HOLD_AT)
            @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial
    begin : stimulus
        int idle_tab [0:3];
        int stall_tab [0:3];
        int ph;
        int n;
        int len;
        int i;
        idle_tab  = '{0, 56, 0, 13};
        stall_tab = '{0, 0, 56, 13};

        // single-sample records at both extremes
        queue_sample(16'sh7FFF, 1'b1, 0, 0, 1'b0);
        queue_sample(16'sh8000, 1'b1, 0, 0, 1'b0);
        // short record, shorter than the lobe radius plus one
        queue_sample(16'sd1000, 1'b0, 0, 0, 1'b0);
        queue_sample(-16'sd2000, 1'b0, 0, 0, 1'b0);
        queue_sample(16'sd3000, 1'b0, 0, 0, 1'b0);
        queue_sample(-16'sd4000, 1'b1, 0, 0, 1'b0);
        // exactly lobe radius plus one, alternating extremes for saturation
        for (i = 0; i < LOBE + 1; i++)
            queue_sample((i % 2 == 0) ? 16'sh7FFF : 16'sh8000, i == LOBE, 0, 0, 1'b0);
        // longer record reaching steady state
        queue_sample(16'sh5555, 1'b0, 0, 0, 1'b0);
        for (i = 0; i < 7; i++)
            queue_sample((i % 2 == 0) ? 16'sh8000 : 16'sh7FFF, 1'b0, 0, 0, 1'b0);
        queue_sample(16'shAAAA, 1'b0, 0, 0, 1'b0);
        queue_sample(16'sh0000, 1'b1, 0, 0, 1'b0);

        for (ph = 0; ph < 4; ph++)
        begin
            n = 0;
            while (n < 18)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
                // first request of each phase waits for the block to drain
                for (i = 0; i < len; i++)
                    queue_sample(pick_sample(), i == len - 1, idle_tab[ph], stall_tab[ph],
                                 n == 0 && i == 0);
                n += len;
            end
        end

        @(posedge rst_n);
        while (n_accepted < n_total)
            @(posedge clk);
        while (interp_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0)
            $display("sinc_polyphase_upsampler_top test passed");
        else
            $display("sinc_polyphase_upsampler_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/spu_pkg.sv
rtl/core/spu_ctrl.sv
rtl/core/spu_datapath.sv
rtl/core/sinc_polyphase_upsampler_top.sv
tb/tb.sv
